[sv/lpsd_pkg.sv]
package lpsd_pkg;

  localparam logic [1:0] PHASE_LEN_HIGH = 2'd0;
  localparam logic [1:0] PHASE_LEN_LOW  = 2'd1;
  localparam logic [1:0] PHASE_PAYLOAD  = 2'd2;
  localparam logic [1:0] PHASE_CLOSED   = 2'd3;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_OVERSIZE = 2'd2;

  localparam logic [15:0] MAX_FRAME_LENGTH_RESET = 16'd8192;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [1:0]  kind;
    logic        frame_end;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

[sv/length_prefixed_stream_deframer_top.sv]
// channel  | handshake                     | contents
// ---------+-------------------------------+-------------------------------------------
// s_axis   | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
// m_axis   | m_axis_tvalid / m_axis_tready | tdata payload_byte, frame_length;
//          |                               | tlast frame_end; tuser kind
// cfg      | cfg_wr_en                     | cfg_wr_data max_frame_length
//
// One item per cycle while the output register is free or being drained; each item
// is decoded and any result lands in the output register the cycle after acceptance.
// Input is taken whenever the output register is empty or being drained.
// Synchronous active-high reset: header phase, max length 8192, no result held.
// Length high bytes, in-range nonzero low bytes, post-oversize bytes: no result.
module length_prefixed_stream_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length
  output logic        m_axis_tlast,   // frame_end
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data     // [15:0] max_frame_length
);

  logic [15:0]      max_frame_length;
  logic [1:0]       phase, phase_next;
  logic [7:0]       length_high, length_high_next;
  logic [15:0]      length_held, length_held_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic             out_valid;
  lpsd_pkg::result_t out_res, res_next;
  logic             emit;
  logic             in_fire;
  logic [15:0]      len;
  logic [15:0]      left_dec;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign len           = {length_high, s_axis_tdata};
  assign left_dec      = bytes_left - 16'd1;

  always_comb begin
    phase_next       = phase;
    length_high_next = length_high;
    length_held_next = length_held;
    bytes_left_next  = bytes_left;
    emit             = 1'b0;
    res_next         = '0;
    unique case (phase)
      lpsd_pkg::PHASE_LEN_HIGH: begin
        length_high_next = s_axis_tdata;
        phase_next       = lpsd_pkg::PHASE_LEN_LOW;
      end
      lpsd_pkg::PHASE_LEN_LOW: begin
        length_held_next = len;
        if (len >= max_frame_length) begin
          bytes_left_next       = '0;
          phase_next            = lpsd_pkg::PHASE_CLOSED;
          emit                  = 1'b1;
          res_next.frame_end    = 1'b1;
          res_next.kind         = lpsd_pkg::KIND_OVERSIZE;
          res_next.frame_length = len;
        end else if (len == 16'd0) begin
          bytes_left_next    = '0;
          phase_next         = lpsd_pkg::PHASE_LEN_HIGH;
          emit               = 1'b1;
          res_next.frame_end = 1'b1;
          res_next.kind      = lpsd_pkg::KIND_EMPTY;
        end else begin
          bytes_left_next = len;
          phase_next      = lpsd_pkg::PHASE_PAYLOAD;
        end
      end
      lpsd_pkg::PHASE_PAYLOAD: begin
        bytes_left_next       = left_dec;
        emit                  = 1'b1;
        res_next.payload_byte = s_axis_tdata;
        res_next.kind         = lpsd_pkg::KIND_DATA;
        res_next.frame_length = length_held;
        if (left_dec == 16'd0) begin
          phase_next         = lpsd_pkg::PHASE_LEN_HIGH;
          res_next.frame_end = 1'b1;
        end
      end
      lpsd_pkg::PHASE_CLOSED: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= lpsd_pkg::MAX_FRAME_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_frame_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lpsd_pkg::PHASE_LEN_HIGH;
      length_high <= '0;
      length_held <= '0;
      bytes_left  <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      length_high <= length_high_next;
      length_held <= length_held_next;
      bytes_left  <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.frame_length, out_res.payload_byte};
  assign m_axis_tlast  = out_res.frame_end;
  assign m_axis_tuser  = out_res.kind;

endmodule

[tb/tb.sv]
module tb;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned DRAIN_CYCLES = 4;

  class deframe_tracker;
    logic [1:0]  phase;
    logic [7:0]  len_high;
    logic [15:0] len_held;
    logic [15:0] left;
    logic [15:0] max_len;
    lpsd_pkg::result_t pending_results[$];
    int unsigned errors;

    function new();
      phase    = lpsd_pkg::PHASE_LEN_HIGH;
      len_high = '0;
      len_held = '0;
      left     = '0;
      max_len  = lpsd_pkg::MAX_FRAME_LENGTH_RESET;
      errors   = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      lpsd_pkg::result_t r;
      logic [15:0]       len;
      r = '0;
      case (phase)
        lpsd_pkg::PHASE_LEN_HIGH: begin
          len_high = b;
          phase = lpsd_pkg::PHASE_LEN_LOW;
        end
        lpsd_pkg::PHASE_LEN_LOW: begin
          len = {len_high, b};
          len_held = len;
          // oversize compare comes before the zero test
          if (len >= max_len) begin
            left = '0;
            phase = lpsd_pkg::PHASE_CLOSED;
            r.frame_end = 1'b1;
            r.kind = lpsd_pkg::KIND_OVERSIZE;
            r.frame_length = len;
            pending_results.push_back(r);
          end else if (len == 16'd0) begin
            left = '0;
            phase = lpsd_pkg::PHASE_LEN_HIGH;
            r.frame_end = 1'b1;
            r.kind = lpsd_pkg::KIND_EMPTY;
            r.frame_length = '0;
            pending_results.push_back(r);
          end else begin
            left = len;
            phase = lpsd_pkg::PHASE_PAYLOAD;
          end
        end
        lpsd_pkg::PHASE_PAYLOAD: begin
          left = left - 16'd1;
          r.payload_byte = b;
          r.kind = lpsd_pkg::KIND_DATA;
          r.frame_length = len_held;
          r.frame_end = (left == 16'd0);
          if (left == 16'd0) phase = lpsd_pkg::PHASE_LEN_HIGH;
          pending_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(lpsd_pkg::result_t got);
      lpsd_pkg::result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with none expected: %p", got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("kind", want.kind, got.kind);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  bit          steady;
  int unsigned cycles;

  deframe_tracker tracker = new();

  length_prefixed_stream_deframer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("length_prefixed_stream_deframer_top verification failed");
    $finish;
  end

  // receiver: checks every accepted result, stalls at random unless steady
  initial begin
    lpsd_pkg::result_t got;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_byte = m_axis_tdata[7:0];
        got.frame_length = m_axis_tdata[23:8];
        got.frame_end    = m_axis_tlast;
        got.kind         = m_axis_tuser;
        tracker.check_result(got);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 19);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_byte(b);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // drop valid, wait for all results, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.max_len = v;
  endtask

  initial begin
    int unsigned count;
    int unsigned len;
    int unsigned r;
    logic [15:0] limit;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty frame, short frames, payload extremes
    send_header(16'd0);
    send_header(16'd1);
    send_byte(8'hFF);
    send_header(16'd2);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_header(16'd3);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);

    // new max written mid-frame only applies from the next header
    send_header(16'd5);
    write_max(16'd3);
    send_payload(5);
    send_header(16'd2);
    send_payload(2);
    send_header(16'd0);

    write_max(16'd1);
    send_header(16'd0);
    send_header(16'd0);

    // largest frame that still fits under the max
    write_max(16'd40);
    send_header(16'd39);
    send_payload(39);

    // random frames under several max settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: limit = lpsd_pkg::MAX_FRAME_LENGTH_RESET;
        1: limit = 16'hFFFF;
        2: limit = 16'($urandom_range(12, 2));
        3: limit = 16'd1;
        default: limit = 16'($urandom_range(400, 13));
      endcase
      write_max(limit);
      steady = (p == 2);
      count = 0;
      while (count < 120) begin
        r = $urandom_range(99);
        if (r < 10) len = 0;
        else if (r < 80) len = $urandom_range(8, 1);
        else if (r < 95) len = $urandom_range(40, 9);
        else if (r < 99) len = $urandom_range(300, 41);
        else len = $urandom_range(1500, 256);
        if (len >= limit) len = len % limit;
        send_header(16'(len));
        send_payload(len);
        count += 2 + len;
      end
      steady = 1'b0;
    end

    // link closes once per run, so pick one way to close it
    case ($urandom_range(2))
      0: begin
        write_max(16'd0);
        send_header(16'd0);
      end
      1: begin
        limit = 16'($urandom_range(65535, 1));
        write_max(limit);
        send_header(limit);
      end
      default: begin
        write_max(16'($urandom_range(65535, 1)));
        send_header(16'hFFFF);
      end
    endcase
    send_payload(30);

    settle();
    if (tracker.errors == 0) begin
      $display("length_prefixed_stream_deframer_top verification clean");
    end else begin
      $display("length_prefixed_stream_deframer_top verification failed");
    end
    $finish;
  end

endmodule
